// ===== design/erp_pkg.sv =====
// shared types and constants for the euclidean rhythm pattern block
package erp_pkg;

    localparam int CNT_W = 5;
    localparam int PAT_W = 16;
    localparam int CNT_MAX = 2**CNT_W - 1;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_FULL,
        MODE_SPARSE,
        MODE_DENSE
    } mode_t;

    typedef struct packed {
        mode_t            mode;
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] per;
        logic [CNT_W-1:0] rem;
    } gen_cfg_t;

endpackage

// ===== design/erp_div.sv =====
// restoring divider, one quotient bit per cycle
module erp_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [erp_pkg::CNT_W-1:0]  dividend,
    input  logic [erp_pkg::CNT_W-1:0]  divisor,
    output logic                       done,
    output logic [erp_pkg::CNT_W-1:0]  quotient,
    output logic [erp_pkg::CNT_W-1:0]  remainder
);

    localparam int W = erp_pkg::CNT_W;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  den_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[W-1]};
        diff    = shifted - {1'b0, den_reg};
        if (shifted >= {1'b0, den_reg})
        begin
            rem_next = diff[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== design/erp_gen.sv =====
// step sequencer, shifts one pattern bit per cycle
module erp_gen (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  erp_pkg::gen_cfg_t          cfg,
    output logic                       done,
    output logic [erp_pkg::PAT_W-1:0]  pattern
);

    localparam int W = erp_pkg::CNT_W;
    localparam int PW = erp_pkg::PAT_W;
    localparam int POS_W = $clog2(PW);

    erp_pkg::gen_cfg_t cfg_reg;
    logic [PW-1:0]     pat_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [W-1:0]      j_reg;
    logic [W-1:0]      i_reg;
    logic              run_reg;
    logic              done_reg;

    logic              in_range;
    logic              step_bit;
    logic              extra;
    logic [W:0]        lead;
    logic [W:0]        glen;
    logic              group_end;

    always_comb
    begin
        in_range = {{(W - POS_W){1'b0}}, pos_reg} < cfg_reg.total;
        extra    = i_reg < cfg_reg.rem;
        lead     = (cfg_reg.mode == erp_pkg::MODE_DENSE) ? (W+1)'(2) : (W+1)'(1);
        glen     = lead + {1'b0, cfg_reg.per} + {{W{1'b0}}, extra};
        // last step of a group when j + 1 reaches the group length
        group_end = ({1'b0, j_reg} + (W+1)'(1)) == glen;
        case (cfg_reg.mode)
            erp_pkg::MODE_ZERO:   step_bit = 1'b0;
            erp_pkg::MODE_FULL:   step_bit = in_range;
            erp_pkg::MODE_SPARSE: step_bit = in_range && (j_reg == '0);
            erp_pkg::MODE_DENSE:  step_bit = in_range && (j_reg != W'(1));
            default:              step_bit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
            end
            else if (run_reg && (pos_reg == POS_W'(PW - 1)))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cfg_reg <= cfg;
            pos_reg <= '0;
            j_reg   <= '0;
            i_reg   <= '0;
        end
        else if (run_reg)
        begin
            // step p ends up at bit p after all shifts
            pat_reg <= {step_bit, pat_reg[PW-1:1]};
            pos_reg <= pos_reg + 1'b1;
            if (group_end)
            begin
                j_reg <= '0;
                i_reg <= i_reg + 1'b1;
            end
            else
            begin
                j_reg <= j_reg + 1'b1;
            end
        end
    end

    assign done    = done_reg;
    assign pattern = pat_reg;

endmodule

// ===== design/euclidean_rhythm_pattern.sv =====
// top level of the euclidean rhythm pattern generator
//
// usage: drive step_count and hit_count and raise start while busy is low;
// that edge is the input transfer. busy goes high on the next cycle and
// stays high until the result has been shown.
// the result appears on pattern with done high for exactly one cycle;
// bit i of pattern is set when step i is a hit, bits at or past the
// step count are zero. step_count above MAX_STEPS is clamped to it.
// a new item is taken only once busy is low again; items do not overlap.
// the work is done by a bit-serial divider that splits the rests
// (or surplus hits) into groups, followed by a sequencer that shifts one
// step per cycle into a 16-bit shift register.
// the receiver cannot hold a result off: it must take it while done is high.
// reset clears the controller; no result is pending afterwards.
module euclidean_rhythm_pattern #(
    parameter int MAX_STEPS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [erp_pkg::CNT_W-1:0]  step_count,
    input  logic [erp_pkg::CNT_W-1:0]  hit_count,
    output logic                       done,
    output logic [erp_pkg::PAT_W-1:0]  pattern
);

    localparam int W = erp_pkg::CNT_W;
    localparam int SAT_LIMIT = (MAX_STEPS > erp_pkg::CNT_MAX) ? erp_pkg::CNT_MAX : MAX_STEPS;
    localparam logic [W-1:0] SAT_STEPS = W'(SAT_LIMIT);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_GEN  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    erp_pkg::mode_t    mode_reg;
    logic [W-1:0]      tot_reg;

    logic              accept;
    logic [W-1:0]      tot_in;
    logic [W-1:0]      rests_in;
    erp_pkg::mode_t    mode_in;
    logic [W-1:0]      num_in;
    logic [W-1:0]      den_in;

    logic              div_done;
    logic [W-1:0]      div_quo;
    logic [W-1:0]      div_rem;
    logic              gen_start;
    logic              gen_done;
    erp_pkg::gen_cfg_t gen_cfg;

    assign accept = start && (state_reg == S_IDLE);

    always_comb
    begin
        tot_in   = (step_count > SAT_STEPS) ? SAT_STEPS : step_count;
        rests_in = tot_in - hit_count;
        if ((tot_in == '0) || (hit_count == '0))
            mode_in = erp_pkg::MODE_ZERO;
        else if (hit_count >= tot_in)
            mode_in = erp_pkg::MODE_FULL;
        else if (rests_in >= hit_count)
            mode_in = erp_pkg::MODE_SPARSE;
        else
            mode_in = erp_pkg::MODE_DENSE;
        // sparse: rests over hits; dense: surplus hits over rests
        if (mode_in == erp_pkg::MODE_SPARSE)
        begin
            num_in = rests_in;
            den_in = hit_count;
        end
        else
        begin
            num_in = hit_count - rests_in;
            den_in = rests_in;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        gen_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    gen_start  = 1'b1;
                    state_next = S_GEN;
                end
            end
            S_GEN:
            begin
                if (gen_done)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode_in;
            tot_reg  <= tot_in;
        end
    end

    always_comb
    begin
        gen_cfg.mode  = mode_reg;
        gen_cfg.total = tot_reg;
        gen_cfg.per   = div_quo;
        gen_cfg.rem   = div_rem;
    end

    erp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .dividend  (num_in),
        .divisor   (den_in),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    erp_gen u_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (gen_start),
        .cfg     (gen_cfg),
        .done    (gen_done),
        .pattern (pattern)
    );

    assign busy = (state_reg != S_IDLE);
    assign done = gen_done;

endmodule

// ===== design/erp_chk.sv =====
// port-level checker for the rhythm pattern block and its bind
module erp_chk (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic [erp_pkg::PAT_W-1:0]  pattern
);

    // a result only shows up while an item is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transfer did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result shown for more than one cycle");

    // busy only drops right after the result transfer
    a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && $past(busy) && $past(rst_n)) |-> $past(done))
        else $error("busy dropped without a result");

    a_pattern_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(pattern))
        else $error("unknown pattern on result");

endmodule

bind euclidean_rhythm_pattern erp_chk u_erp_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .pattern (pattern)
);
